// ===== hw/rtl/mhpq_pkg.sv =====
// Shared types and constants for the min-heap priority queue.
// No dependencies; imported by mhpq_ram and min_heap_priority_queue.
package mhpq_pkg;

  localparam int IDX_W  = 16;
  localparam int KEY_W  = 32;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;

  localparam logic [IDX_W-1:0] NO_INDEX = '1;
  localparam logic [KEY_W-1:0] NO_KEY   = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CMP,
    S_POP_ROOT,
    S_POP_LAST,
    S_DN_L,
    S_DN_R,
    S_FIN
  } state_t;

endpackage

// ===== hw/rtl/mhpq_ram.sv =====
// Heap entry storage: one write port, one read port, registered read data.
// Depends on mhpq_pkg for the entry type.
module mhpq_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  mhpq_pkg::entry_t   wr_data,
  input  logic [AW-1:0]      rd_addr,
  output mhpq_pkg::entry_t   rd_data
);
  import mhpq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/min_heap_priority_queue.sv =====
// Binary min-heap priority queue of (index, key) entries, top level.
// Depends on mhpq_pkg and mhpq_ram.
//
// Usage:
//   Command channel: an item is taken at a rising edge where start is high
//   and busy is low; command selects push, pop or clear, node_index and
//   distance_key carry the entry on a push.
//   Result channel: done is high for exactly one cycle per item, with
//   status, popped_index, popped_key and entry_count valid in that cycle.
//   The receiver cannot stall; results are never held back.
// Sequencing:
//   Clear, a dropped push, a pop on an empty heap and a push into an empty
//   heap finish at the accept edge without leaving idle; a pop that leaves
//   the heap empty finishes in the root-read state. Other pushes climb the
//   heap level by level in the sift-up state, with a final write state when
//   the entry reaches the root. Other pops read the root, then the last
//   entry, then sift down level by level (left child, then right child when
//   it exists), with a final write state when the entry settles in a leaf.
//   Every heap level costs one read-compare-write on the entry RAM (one read
//   port, one write port); sift-down reads twice at a level with two children.
//   busy stays high until the item's done cycle; a new item may be taken
//   in the done cycle itself.
// Reset: rst clears the entry count and the controller; RAM contents are
// not cleared and are only read below the entry count.
module min_heap_priority_queue #(
  parameter int CAPACITY = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [mhpq_pkg::CMD_W-1:0]            command,
  input  logic [mhpq_pkg::IDX_W-1:0]            node_index,
  input  logic [mhpq_pkg::KEY_W-1:0]            distance_key,
  output logic                                  done,
  output logic [mhpq_pkg::STAT_W-1:0]           status,
  output logic [mhpq_pkg::IDX_W-1:0]            popped_index,
  output logic [mhpq_pkg::KEY_W-1:0]            popped_key,
  output logic [$clog2(CAPACITY+1)-1:0]         entry_count
);
  import mhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = AW + 2;
  localparam logic [CW-1:0] FULL = CW'(CAPACITY);

  state_t state, state_next;

  logic [CW-1:0] size;
  logic [AW-1:0] pos;
  entry_t        cur;
  entry_t        left_q;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic          finish;

  logic          accept;
  cmd_e_t        cmd;
  logic          is_full;
  logic          is_empty;
  logic [AW-1:0] push_parent;
  logic [AW-1:0] up;
  logic [AW-1:0] up_parent;
  logic          up_move;
  logic [LW-1:0] size_ext;
  logic [LW-1:0] lc;
  logic [LW-1:0] rc;
  logic          rc_ok;
  logic          deciding;
  entry_t        cand;
  logic          sel_left;
  logic          sel_right;
  logic [KEY_W-1:0] best_key;
  logic          moving;
  logic [AW-1:0] best_addr;
  entry_t        best_entry;
  logic [LW-1:0] best_lc;
  logic          best_lc_ok;

  mhpq_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy        = (state != S_IDLE);
  assign accept      = start && !busy;
  assign cmd         = cmd_e_t'(command);
  assign entry_count = size;
  assign is_full     = (size == FULL);
  assign is_empty    = (size == '0);

  // parent index of the slot a push lands in
  assign push_parent = (size[AW-1:0] - AW'(1)) >> 1;
  assign up          = (pos - AW'(1)) >> 1;
  assign up_parent   = (up - AW'(1)) >> 1;
  assign up_move     = (rd_data.key > cur.key);

  assign size_ext = LW'(size);
  assign lc       = (LW'(pos) << 1) + LW'(1);
  assign rc       = lc + LW'(1);
  assign rc_ok    = (rc < size_ext);
  assign deciding = ((state == S_DN_L) && !rc_ok) || (state == S_DN_R);

  // sift-down choice: left only if strictly smaller, right only if smaller still
  assign cand       = (state == S_DN_L) ? rd_data : left_q;
  assign sel_left   = (cand.key < cur.key);
  assign best_key   = sel_left ? cand.key : cur.key;
  assign sel_right  = (state == S_DN_R) && (rd_data.key < best_key);
  assign moving     = sel_left || sel_right;
  assign best_addr  = sel_right ? rc[AW-1:0] : lc[AW-1:0];
  assign best_entry = sel_right ? rd_data : cand;
  assign best_lc    = (LW'(best_addr) << 1) + LW'(1);
  assign best_lc_ok = (best_lc < size_ext);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_PUSH: begin
              if (!is_full && !is_empty) state_next = S_UP_CMP;
            end
            CMD_POP: begin
              if (!is_empty) state_next = S_POP_ROOT;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_UP_CMP: begin
        if (!up_move) state_next = S_IDLE;
        else if (up != '0) state_next = S_UP_CMP;
        else state_next = S_FIN;
      end
      S_POP_ROOT: state_next = is_empty ? S_IDLE : S_POP_LAST;
      S_POP_LAST: state_next = (size_ext > LW'(1)) ? S_DN_L : S_FIN;
      S_DN_L, S_DN_R: begin
        if ((state == S_DN_L) && rc_ok) state_next = S_DN_R;
        else if (!moving) state_next = S_IDLE;
        else if (best_lc_ok) state_next = S_DN_L;
        else state_next = S_FIN;
      end
      S_FIN: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // RAM port and finish strobe
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = cur;
    rd_addr = '0;
    finish  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_PUSH: begin
              if (is_full) begin
                finish = 1'b1;
              end else if (is_empty) begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = '{index: node_index, key: distance_key};
                finish  = 1'b1;
              end else begin
                rd_addr = push_parent;
              end
            end
            CMD_POP: begin
              if (is_empty) finish = 1'b1;
              else rd_addr = '0;
            end
            default: finish = 1'b1;
          endcase
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (up_move) begin
          wr_data = rd_data;
          rd_addr = up_parent;
        end else begin
          finish = 1'b1;
        end
      end
      S_POP_ROOT: begin
        rd_addr = size[AW-1:0];
        finish  = is_empty;
      end
      S_POP_LAST: begin
        rd_addr = AW'(1);
      end
      S_DN_L, S_DN_R: begin
        if ((state == S_DN_L) && rc_ok) begin
          rd_addr = rc[AW-1:0];
        end else if (!moving) begin
          wr_en  = 1'b1;
          finish = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_data = best_entry;
          rd_addr = best_lc[AW-1:0];
        end
      end
      S_FIN: begin
        wr_en  = 1'b1;
        finish = 1'b1;
      end
      default: finish = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      size  <= '0;
    end else begin
      state <= state_next;
      done  <= finish;
      if (accept) begin
        case (cmd)
          CMD_PUSH:  if (!is_full) size <= size + CW'(1);
          CMD_POP:   if (!is_empty) size <= size - CW'(1);
          CMD_CLEAR: size <= '0;
          default:   size <= size;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      if ((cmd == CMD_PUSH) && is_full) status <= ST_FULL;
      else if ((cmd == CMD_POP) && is_empty) status <= ST_EMPTY;
      else status <= ST_OK;
      popped_index <= NO_INDEX;
      popped_key   <= NO_KEY;
      cur          <= '{index: node_index, key: distance_key};
      pos          <= (cmd == CMD_PUSH) ? size[AW-1:0] : '0;
    end
    if (state == S_POP_ROOT) begin
      popped_index <= rd_data.index;
      popped_key   <= rd_data.key;
    end
    if (state == S_POP_LAST) cur <= rd_data;
    if (state == S_DN_L) left_q <= rd_data;
    if (deciding && moving) pos <= best_addr;
    if ((state == S_UP_CMP) && up_move) pos <= up;
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while an item is in flight");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= FULL)
    else $error("entry count above capacity");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_POP) && is_empty) |=> (done && (status == ST_EMPTY)))
    else $error("pop on empty heap not reported next cycle");

  a_push_full: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_PUSH) && is_full) |=> (done && (status == ST_FULL)
      && $stable(entry_count)))
    else $error("push on full heap not dropped");

endmodule
